>>> rtl/hcc_pkg.sv
// Shared types, constants and functions of the chunked body decoder with CRC-32 check.
package hcc_pkg;

  localparam int OFF_W = 24;
  localparam int CRC_W = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [1:0] CRLF_LAST = 2'd3;

  typedef enum logic [0:0] {
    REG_EXP_SIZE = 1'b0,
    REG_EXP_CRC  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SIZE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC     = 2'd1,
    ST_EARLY   = 2'd2,
    ST_BADSIZE = 2'd3
  } status_t;

  // One result of the parser, before the output register
  typedef struct packed {
    logic             emit;
    logic             is_payload;
    logic             last;
    status_t          status;
    logic [CRC_W-1:0] crc;
    logic [OFF_W-1:0] offset;
    logic [7:0]       data;
  } res_t;

  // Reflected CRC-32 over one byte, one bit per step
  function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  // Status of a finished body from the final CRC
  function automatic status_t crc_status(input logic [CRC_W-1:0] exp_crc,
                                         input logic [CRC_W-1:0] crc_fin);
    return (exp_crc != '0 && exp_crc != crc_fin) ? ST_CRC : ST_OK;
  endfunction

endpackage

>>> rtl/hcc_in_stage.sv
// Input register stage: holds one accepted byte until the parser consumes it.
module hcc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       dn_free,
  output logic       step,
  output logic [7:0] s_byte,
  output logic       s_new
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       new_r;

  // Consume the held beat when the result side can take it
  assign step      = valid_r && dn_free;
  assign in_tready = !valid_r || dn_free;
  assign s_byte    = byte_r;
  assign s_new     = new_r;

  // Hold the control bit under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Capture payload on each accepted beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      new_r  <= in_tuser;
    end
  end

endmodule

>>> rtl/hcc_parser.sv
// Header skip, chunk size parser, payload counter and CRC-32 state.
module hcc_parser #(
  parameter int SIZE_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [7:0]               s_byte,
  input  logic                     s_new,
  input  logic [hcc_pkg::OFF_W-1:0] exp_size,
  input  logic [hcc_pkg::CRC_W-1:0] exp_crc,
  output hcc_pkg::res_t            res
);
  import hcc_pkg::*;

  phase_t               phase_r, phase_nxt, phase_cur;
  logic [1:0]           prog_r, prog_nxt, prog_cur;
  logic [SIZE_BITS-1:0] left_r, left_nxt, left_cur;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt, acc_cur;
  logic                 ext_r, ext_nxt, ext_cur;
  logic [CRC_W-1:0]     crc_r, crc_nxt, crc_cur, crc_upd;
  logic [OFF_W-1:0]     off_r, off_nxt, off_cur;
  logic [OFF_W:0]       off_inc;
  logic [SIZE_BITS-1:0] left_dec;
  logic [4:0]           hex;

  // Apply new-response clear before parsing the byte
  always_comb begin
    if (s_new) begin
      phase_cur = PH_HEADER;
      prog_cur  = '0;
      left_cur  = '0;
      acc_cur   = '0;
      ext_cur   = 1'b0;
      crc_cur   = CRC_ONES;
      off_cur   = '0;
    end else begin
      phase_cur = phase_r;
      prog_cur  = prog_r;
      left_cur  = left_r;
      acc_cur   = acc_r;
      ext_cur   = ext_r;
      crc_cur   = crc_r;
      off_cur   = off_r;
    end
  end

  assign crc_upd  = crc32_byte(crc_cur, s_byte);
  assign off_inc  = {1'b0, off_cur} + (OFF_W+1)'(1);
  assign left_dec = left_cur - SIZE_BITS'(1);
  assign hex      = hex_decode(s_byte);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt      = phase_cur;
    prog_nxt       = prog_cur;
    left_nxt       = left_cur;
    acc_nxt        = acc_cur;
    ext_nxt        = ext_cur;
    crc_nxt        = crc_cur;
    off_nxt        = off_cur;
    res            = '0;
    res.offset     = off_cur;
    res.crc        = crc_cur ^ CRC_ONES;
    res.status     = ST_OK;
    case (phase_cur)
      PH_HEADER: begin
        if (prog_cur == CRLF_LAST && s_byte == CH_LF) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          ext_nxt   = 1'b0;
          prog_nxt  = '0;
          if (exp_size == '0) begin
            phase_nxt  = PH_DONE;
            res.emit   = 1'b1;
            res.last   = 1'b1;
            res.status = crc_status(exp_crc, crc_cur ^ CRC_ONES);
          end
        end else if (s_byte == (prog_cur[0] ? CH_LF : CH_CR)) begin
          prog_nxt = prog_cur + 2'd1;
        end else begin
          prog_nxt = (s_byte == CH_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_SIZE: begin
        if (s_byte == CH_LF) begin
          if (prog_cur != '0 && acc_cur == '0) begin
            phase_nxt  = PH_DONE;
            res.emit   = 1'b1;
            res.last   = 1'b1;
            res.status = ST_EARLY;
          end else begin
            if (prog_cur != '0) begin
              left_nxt  = acc_cur;
              phase_nxt = PH_DATA;
            end
            acc_nxt  = '0;
            ext_nxt  = 1'b0;
            prog_nxt = '0;
          end
        end else if (ext_cur) begin
          ext_nxt = 1'b1;
        end else if (s_byte == CH_SEMI) begin
          ext_nxt = 1'b1;
        end else if (s_byte == CH_CR || s_byte == CH_SP || s_byte == CH_TAB) begin
          ext_nxt = 1'b0;
        end else if (!hex[4] || acc_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
          phase_nxt  = PH_DONE;
          res.emit   = 1'b1;
          res.last   = 1'b1;
          res.status = ST_BADSIZE;
        end else begin
          acc_nxt  = {acc_cur[SIZE_BITS-5:0], hex[3:0]};
          prog_nxt = 2'd1;
        end
      end
      PH_DATA: begin
        crc_nxt        = crc_upd;
        off_nxt        = off_inc[OFF_W-1:0];
        left_nxt       = left_dec;
        res.emit       = 1'b1;
        res.is_payload = 1'b1;
        res.data       = s_byte;
        res.crc        = crc_upd ^ CRC_ONES;
        if (off_inc >= {1'b0, exp_size}) begin
          phase_nxt  = PH_DONE;
          res.last   = 1'b1;
          res.status = crc_status(exp_crc, crc_upd ^ CRC_ONES);
        end else if (left_dec == '0) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          ext_nxt   = 1'b0;
          prog_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // Advance control state on each consumed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      prog_r  <= '0;
      left_r  <= '0;
      acc_r   <= '0;
      ext_r   <= 1'b0;
      crc_r   <= CRC_ONES;
      off_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      prog_r  <= prog_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      ext_r   <= ext_nxt;
      crc_r   <= crc_nxt;
      off_r   <= off_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !s_new && phase_r == PH_DONE) |-> !res.emit)
    else $error("result after body finished");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.emit && res.last) |=> (phase_r == PH_DONE))
    else $error("parser not done after last result");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res.emit && !res.last) |-> (res.status == ST_OK))
    else $error("nonzero status on a non-final result");
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.is_payload && !res.last) |-> ({1'b0, off_r} < {1'b0, exp_size}))
    else $error("payload offset past expected size");
`endif

endmodule

>>> rtl/http_chunked_body_crc_check.sv
// Top level of the HTTP chunked body decoder with CRC-32 check.
// Takes one response byte per clock and sustains one byte per cycle with no
// gaps while out_tready stays high. An accepted byte sits in the input
// register while the parser and its byte-wide CRC-32 step work on it
// combinationally. Its result is loaded into the result register, which
// presents it on the output, when the parser consumes the byte. A result held
// by a low out_tready blocks the input until it is taken. The header is
// skipped to the blank line, chunk size lines are parsed, and every payload
// byte comes out with its offset and running CRC; the final beat (tlast)
// carries the status. The byte-wide CRC update, hex decode and CR/LF, size
// and offset compares sit between registers, which sets the one-byte-per-clock
// figure. tuser on the input marks the first byte of a new response and
// clears the parser.
module http_chunked_body_crc_check #(
  parameter int SIZE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] new_response
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [31:8] out_offset,
                                  // [33:32] status, [65:34] crc_value, zero fill
  output logic        out_tuser,  // [0] is_payload
  output logic        out_tlast
);
  import hcc_pkg::*;

  logic [OFF_W-1:0] exp_size_r;
  logic [CRC_W-1:0] exp_crc_r;
  logic             dn_free;
  logic             step;
  logic [7:0]       s_byte;
  logic             s_new;
  res_t             res;
  logic             ovalid_r;
  logic [71:0]      odata_r;
  logic             ouser_r;
  logic             olast_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_size_r <= '0;
      exp_crc_r  <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_EXP_SIZE: exp_size_r <= cfg_wdata[OFF_W-1:0];
        REG_EXP_CRC:  exp_crc_r  <= cfg_wdata;
        default:      exp_crc_r  <= exp_crc_r;
      endcase
    end
  end

  assign dn_free = !ovalid_r || out_tready;

  hcc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .dn_free   (dn_free),
    .step      (step),
    .s_byte    (s_byte),
    .s_new     (s_new)
  );

  hcc_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .s_byte   (s_byte),
    .s_new    (s_new),
    .exp_size (exp_size_r),
    .exp_crc  (exp_crc_r),
    .res      (res)
  );

  // Load the result register when it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (dn_free) begin
      ovalid_r <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_free && step && res.emit) begin
      odata_r <= {6'd0, res.crc, res.status, res.offset, res.data};
      ouser_r <= res.is_payload;
      olast_r <= res.last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule
